// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the rtl files (included by the core)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define CHK_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CHK_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/slir_pkg.sv =====
package slir_pkg;

  // field widths of the words on both sides
  localparam int WORD_W    = 32;
  localparam int IDX_W     = 4;
  localparam int CMD_W     = 2;
  localparam int CNT_OUT_W = 5;
  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 40;

  typedef logic signed [WORD_W-1:0] word_t;

  // command codes carried on s_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

endpackage

// ===== rtl/core/slir_ram.sv =====
module slir_ram #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  slir_pkg::word_t          wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output slir_pkg::word_t          rdata
);
  import slir_pkg::*;

  word_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sorted_list_insert_remove_core.sv =====
// channel | dir | handshake          | contents
// s       | in  | s_tvalid, s_tready | s_tuser: cmd; s_tdata: value, index
// m       | out | m_tvalid, m_tready | m_tdata: ok, count, is_empty, is_full, read_value
//
// one command at a time; entries live in a single ram with a registered read port
// insert: walk down from the top, moving each larger entry up, then write the value
// remove: scan up for an equal entry, then move each entry above it down one slot
// read: fetch the indexed entry; an unknown command or early failure goes to the result
// rst clears the fill count and handshakes; ram contents are left as they are
// a stalled result is held in the output register and blocks only the next result
`include "assert_macros.svh"

module sorted_list_insert_remove_core #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // value[31:0], index[35:32], zero[39:36]
  input  logic [slir_pkg::S_DATA_W-1:0] s_tdata,
  // cmd[1:0]
  input  logic [slir_pkg::CMD_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // ok[0], count[5:1], is_empty[6], is_full[7], read_value[39:8]
  output logic [slir_pkg::M_DATA_W-1:0] m_tdata
);
  import slir_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);
  localparam logic [CW-1:0] TWO      = CW'(2);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_INS  = 7'b0000010,
    ST_PUT  = 7'b0000100,
    ST_RSCH = 7'b0001000,
    ST_RSHF = 7'b0010000,
    ST_RD   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   ptr, ptr_next;
  word_t           val, val_next;
  logic            res_ok, res_ok_next;
  word_t           res_rd, res_rd_next;

  logic            o_ok;
  logic [CNT_OUT_W-1:0] o_cnt;
  logic            o_empty;
  logic            o_full;
  word_t           o_rd;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  word_t           mem_wdata;
  logic [AW-1:0]   mem_raddr;
  word_t           mem_rdata;

  word_t           in_value;
  logic [IDX_W-1:0] in_index;
  cmd_t            in_cmd;
  logic            out_free;
  logic [CW-1:0]   ptr_inc, ptr_inc2, ptr_dec, ptr_dec2;

  // unpack the input word
  assign in_value = word_t'(s_tdata[WORD_W-1:0]);
  assign in_index = s_tdata[WORD_W+IDX_W-1:WORD_W];
  assign in_cmd   = cmd_t'(s_tuser);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  assign ptr_inc  = ptr + ONE;
  assign ptr_inc2 = ptr + TWO;
  assign ptr_dec  = ptr - ONE;
  assign ptr_dec2 = ptr - TWO;

  slir_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer: walk the ram one entry a cycle, next read issued with each compare
  always_comb begin
    state_next  = state;
    count_next  = count;
    ptr_next    = ptr;
    val_next    = val;
    res_ok_next = res_ok;
    res_rd_next = res_rd;
    mem_we      = 1'b0;
    mem_waddr   = AW'(ptr);
    mem_wdata   = val;
    mem_raddr   = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          val_next    = in_value;
          res_ok_next = 1'b0;
          res_rd_next = '0;
          state_next  = ST_FIN;
          case (in_cmd)
            CMD_INSERT: begin
              if (count == '0) begin
                ptr_next   = '0;
                state_next = ST_PUT;
              end else if (count != FULL_CNT) begin
                mem_raddr  = AW'(count - ONE);
                ptr_next   = count;
                state_next = ST_INS;
              end
            end
            CMD_REMOVE: begin
              if (count != '0) begin
                mem_raddr  = '0;
                ptr_next   = '0;
                state_next = ST_RSCH;
              end
            end
            CMD_READ: begin
              if (IW'(in_index) < IW'(count)) begin
                mem_raddr  = AW'(in_index);
                state_next = ST_RD;
              end
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end
      // rdata is entry ptr-1; move it up while it is larger than the value
      ST_INS: begin
        mem_we = 1'b1;
        if (mem_rdata > val) begin
          mem_wdata = mem_rdata;
          ptr_next  = ptr_dec;
          if (ptr == ONE) begin
            state_next = ST_PUT;
          end else begin
            mem_raddr = AW'(ptr_dec2);
          end
        end else begin
          count_next  = count + ONE;
          res_ok_next = 1'b1;
          state_next  = ST_FIN;
        end
      end
      // drop the value into the bottom slot
      ST_PUT: begin
        mem_we      = 1'b1;
        count_next  = count + ONE;
        res_ok_next = 1'b1;
        state_next  = ST_FIN;
      end
      // rdata is entry ptr; look for the first entry not below the value
      ST_RSCH: begin
        if (mem_rdata < val) begin
          if (ptr_inc == count) begin
            state_next = ST_FIN;
          end else begin
            mem_raddr = AW'(ptr_inc);
            ptr_next  = ptr_inc;
          end
        end else if (mem_rdata != val) begin
          state_next = ST_FIN;
        end else if (ptr_inc == count) begin
          count_next  = count - ONE;
          res_ok_next = 1'b1;
          state_next  = ST_FIN;
        end else begin
          mem_raddr  = AW'(ptr_inc);
          state_next = ST_RSHF;
        end
      end
      // rdata is entry ptr+1; move it down into ptr
      ST_RSHF: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (ptr_inc2 == count) begin
          count_next  = count - ONE;
          res_ok_next = 1'b1;
          state_next  = ST_FIN;
        end else begin
          mem_raddr = AW'(ptr_inc2);
          ptr_next  = ptr_inc;
        end
      end
      ST_RD: begin
        res_ok_next = 1'b1;
        res_rd_next = mem_rdata;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    ptr    <= ptr_next;
    val    <= val_next;
    res_ok <= res_ok_next;
    res_rd <= res_rd_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == ST_FIN && out_free) begin
      o_ok    <= res_ok;
      o_cnt   <= CNT_OUT_W'(count);
      o_empty <= (count == '0);
      o_full  <= (count == FULL_CNT);
      o_rd    <= res_rd;
    end
  end

  assign m_tdata = {o_rd, o_full, o_empty, o_cnt, o_ok};

  `CHK_IMPL(a_count_range, clk, rst, 1'b1, count <= FULL_CNT, "fill count beyond depth")
  `CHK_NEXT(a_count_step, clk, rst, 1'b1, (count == $past(count)) || (count == $past(count) + ONE) || (count == $past(count) - ONE), "fill count jumped")
  `CHK_IMPL(a_write_state, clk, rst, mem_we, (state == ST_INS) || (state == ST_PUT) || (state == ST_RSHF), "ram write outside a move state")
  `CHK_IMPL(a_empty_flag, clk, rst, m_tvalid, o_empty == (o_cnt == '0), "empty flag disagrees with count")

endmodule
